### rtl/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types and constants of the amicable pair checker: result width,
// controller state codes, and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package apc_pkg;

    // Width of the reported divisor sum
    localparam int unsigned SUM_WIDTH = 33;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_TEST,
        ST_DIV,
        ST_ADD_D,
        ST_ADD_Q,
        ST_STEP,
        ST_END,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;    // capture candidate, select first pass
        logic init_pass;  // d = 2, d^2 = 4, sum = 1 (or 0 below two)
        logic div_start;  // clear divider, load dividend
        logic div_step;   // one restoring step
        logic add_d;      // sum += d
        logic add_q;      // sum += quotient
        logic step_d;     // d += 1, d^2 += 2d + 1
        logic end_pass;   // close a divisor-sum pass
        logic emit;       // write the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_small;   // operand below two
        logic past_root;  // d^2 above operand
        logic div_last;   // final divider step this cycle
        logic rem_zero;   // d divides operand
        logic q_eq_d;     // quotient equals d (square root divisor)
        logic need_more;  // first pass done and partner sum is needed
        logic out_busy;   // result register holds an untaken word
    } status_t;

endpackage

### rtl/apc_ctrl.sv
// ----------------------------------------------------------------------------
// apc_ctrl
// Controller of the amicable pair checker: sequences the trial division
// passes and issues commands to the datapath.
// ----------------------------------------------------------------------------
module apc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    input  apc_pkg::status_t  sts,
    output apc_pkg::cmd_t     cmd
);

    apc_pkg::state_t state_reg;
    apc_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = apc_pkg::ST_INIT;
                end
            end
            apc_pkg::ST_INIT:
            begin
                state_next = apc_pkg::ST_TEST;
            end
            apc_pkg::ST_TEST:
            begin
                if (sts.op_small || sts.past_root)
                begin
                    state_next = apc_pkg::ST_END;
                end
                else
                begin
                    state_next = apc_pkg::ST_DIV;
                end
            end
            apc_pkg::ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = apc_pkg::ST_ADD_D;
                end
            end
            apc_pkg::ST_ADD_D:
            begin
                if (sts.rem_zero)
                begin
                    state_next = apc_pkg::ST_ADD_Q;
                end
                else
                begin
                    state_next = apc_pkg::ST_STEP;
                end
            end
            apc_pkg::ST_ADD_Q:
            begin
                state_next = apc_pkg::ST_STEP;
            end
            apc_pkg::ST_STEP:
            begin
                state_next = apc_pkg::ST_TEST;
            end
            apc_pkg::ST_END:
            begin
                if (sts.need_more)
                begin
                    state_next = apc_pkg::ST_INIT;
                end
                else
                begin
                    state_next = apc_pkg::ST_EMIT;
                end
            end
            apc_pkg::ST_EMIT:
            begin
                if (!sts.out_busy || out_ready)
                begin
                    state_next = apc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = apc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            apc_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            apc_pkg::ST_INIT:
            begin
                cmd.init_pass = 1'b1;
            end
            apc_pkg::ST_TEST:
            begin
                cmd.div_start = !(sts.op_small || sts.past_root);
            end
            apc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            apc_pkg::ST_ADD_D:
            begin
                cmd.add_d = sts.rem_zero;
            end
            apc_pkg::ST_ADD_Q:
            begin
                cmd.add_q = !sts.q_eq_d;
            end
            apc_pkg::ST_STEP:
            begin
                cmd.step_d = 1'b1;
            end
            apc_pkg::ST_END:
            begin
                cmd.end_pass = 1'b1;
            end
            apc_pkg::ST_EMIT:
            begin
                cmd.emit = !sts.out_busy || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/apc_dp.sv
// ----------------------------------------------------------------------------
// apc_dp
// Datapath of the amicable pair checker: trial divisor and its square,
// a radix-2 restoring divider, the divisor-sum accumulator and the
// result register.
// ----------------------------------------------------------------------------
module apc_dp
#(
    parameter int unsigned NUMBER_WIDTH = 30
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [NUMBER_WIDTH-1:0]         candidate,
    input  logic                            out_ready,
    input  apc_pkg::cmd_t                   cmd,
    output apc_pkg::status_t                sts,
    output logic                            out_valid,
    output logic [apc_pkg::SUM_WIDTH-1:0]   divisor_sum,
    output logic                            is_pair
);

    // Operand width covers the partner (divisor sum below 8x candidate)
    localparam int unsigned AW  = NUMBER_WIDTH + 3;
    localparam int unsigned DW  = (AW + 1) / 2 + 1;
    localparam int unsigned SQW = 2 * DW;
    localparam int unsigned ACW = AW + 3;
    localparam int unsigned CW  = $clog2(AW);
    localparam int unsigned SW  = apc_pkg::SUM_WIDTH;

    logic [NUMBER_WIDTH-1:0] n_reg;
    logic [AW-1:0]           op_reg;
    logic                    pass_reg;
    logic [DW-1:0]           d_reg;
    logic [SQW-1:0]          dsq_reg;
    logic [ACW-1:0]          acc_reg;
    logic [ACW-1:0]          first_reg;
    logic [AW-1:0]           dvd_reg;
    logic [AW-1:0]           q_reg;
    logic [DW:0]             rem_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    pair_reg;
    logic                    out_valid_reg;
    logic [SW-1:0]           out_sum_reg;
    logic                    out_pair_reg;

    logic [DW:0]             rem_shift;
    logic                    rem_ge;
    logic [DW:0]             rem_next;
    logic                    more;

    // Restoring step: shift in next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg[DW-1:0], dvd_reg[AW-1]};
    assign rem_ge    = rem_shift >= {1'b0, d_reg};
    assign rem_next  = rem_ge ? (rem_shift - {1'b0, d_reg}) : rem_shift;

    assign more = !pass_reg && (acc_reg > ACW'(n_reg));

    // Status
    always_comb
    begin
        sts.op_small  = op_reg < AW'(2);
        sts.past_root = dsq_reg > SQW'(op_reg);
        sts.div_last  = cnt_reg == CW'(AW - 1);
        sts.rem_zero  = rem_reg == '0;
        sts.q_eq_d    = q_reg == AW'(d_reg);
        sts.need_more = more;
        sts.out_busy  = out_valid_reg;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            n_reg    <= candidate;
            op_reg   <= AW'(candidate);
            pass_reg <= 1'b0;
        end
        if (cmd.init_pass)
        begin
            d_reg   <= DW'(2);
            dsq_reg <= SQW'(4);
            acc_reg <= (op_reg < AW'(2)) ? '0 : ACW'(1);
        end
        if (cmd.div_start)
        begin
            dvd_reg <= op_reg;
            q_reg   <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[AW-2:0], 1'b0};
            q_reg   <= {q_reg[AW-2:0], rem_ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.add_d)
        begin
            acc_reg <= acc_reg + ACW'(d_reg);
        end
        if (cmd.add_q)
        begin
            acc_reg <= acc_reg + ACW'(q_reg);
        end
        if (cmd.step_d)
        begin
            d_reg   <= d_reg + DW'(1);
            dsq_reg <= dsq_reg + SQW'({d_reg, 1'b1});
        end
        if (cmd.end_pass)
        begin
            if (!pass_reg)
            begin
                first_reg <= acc_reg;
                pair_reg  <= 1'b0;
            end
            else
            begin
                pair_reg <= acc_reg == ACW'(n_reg);
            end
            if (more)
            begin
                op_reg   <= acc_reg[AW-1:0];
                pass_reg <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_sum_reg  <= SW'(first_reg);
            out_pair_reg <= pair_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign divisor_sum = out_sum_reg;
    assign is_pair     = out_pair_reg;

endmodule

### rtl/amicable_pair_checker.sv
// ----------------------------------------------------------------------------
// amicable_pair_checker
// Tests one candidate at a time for being the smaller member of an
// amicable pair, by trial division of the candidate and of its partner.
// ----------------------------------------------------------------------------
// One candidate is worked at a time; in_ready is high only while the block
// is idle. The time per word is set by the trial-division loop: each trial
// divisor d from 2 up to floor(sqrt(n)) passes through the radix-2
// restoring divider, which builds a quotient of NUMBER_WIDTH+3 bits, and
// through the TEST, ADD_D, ADD_Q (when d divides) and STEP states. A second
// pass over the partner s runs only when s exceeds the candidate. The result
// sits in an output register, so the next candidate is accepted while it
// waits.
module amicable_pair_checker
#(
    parameter int unsigned NUMBER_WIDTH = 30
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [NUMBER_WIDTH-1:0]         candidate,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [apc_pkg::SUM_WIDTH-1:0]   divisor_sum,
    output logic                            is_pair
);

    apc_pkg::cmd_t    cmd;
    apc_pkg::status_t sts;

    apc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    apc_dp #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .candidate   (candidate),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .divisor_sum (divisor_sum),
        .is_pair     (is_pair)
    );

endmodule

### rtl/apc_checker.sv
// ----------------------------------------------------------------------------
// apc_checker
// Port-level assertions for the amicable pair checker, bound to the top.
// ----------------------------------------------------------------------------
module apc_checker
#(
    parameter int unsigned NUMBER_WIDTH = 30
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [NUMBER_WIDTH-1:0]         candidate,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [apc_pkg::SUM_WIDTH-1:0]   divisor_sum,
    input  logic                            is_pair
);

    // One word in flight: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is in flight");

    // Offered input word holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(candidate))
        else $error("input word changed while waiting");

    // A pair always has a partner sum above one
    a_pair_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_pair |-> divisor_sum > apc_pkg::SUM_WIDTH'(1))
        else $error("pair flagged with trivial divisor sum");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(divisor_sum)
            && $stable(is_pair))
        else $error("result word changed while stalled");

endmodule

bind amicable_pair_checker apc_checker #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
) u_apc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .candidate   (candidate),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .divisor_sum (divisor_sum),
    .is_pair     (is_pair)
);

### bench/amicable_pair_checker_test.sv
// ----------------------------------------------------------------------------
// amicable_pair_checker_test
// Self-checking bench for the amicable pair checker. Candidates are sent
// from a queue by a clocked driver. A clocked monitor compares each
// returned word with the divisor sum and pair flag worked out by trial
// division in the bench. Both sides idle at random. The receiver stalls
// once for a long stretch. The sender drains once before going on.
// ----------------------------------------------------------------------------
module amicable_pair_checker_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUMBER_WIDTH = 30;
    localparam int unsigned RUN_LIMIT    = 20_000_000;
    localparam int unsigned RANDOM_COUNT = 80;
    localparam int unsigned TAIL_COUNT   = 20;

    typedef struct {
        logic [NUMBER_WIDTH-1:0] value;
        bit                      drain;  // wait for all results before sending
    } cand_word_t;

    typedef struct {
        logic [apc_pkg::SUM_WIDTH-1:0] sum;
        logic                          pair;
    } verdict_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [NUMBER_WIDTH-1:0]         candidate;
    logic                            out_valid;
    logic                            out_ready;
    logic [apc_pkg::SUM_WIDTH-1:0]   divisor_sum;
    logic                            is_pair;

    cand_word_t  cand_queue[$];
    verdict_t    verdict_queue[$];
    bit          feed_done;
    int unsigned words_sent;
    int unsigned words_seen;
    int unsigned pairs_seen;
    int unsigned error_count;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned stall_count;
    bit          stall_done;
    int unsigned cycle_count;

    amicable_pair_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .candidate   (candidate),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .divisor_sum (divisor_sum),
        .is_pair     (is_pair)
    );

    // Clock, 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sum of proper divisors by trial division, square root counted once
    function automatic longint unsigned divisor_total(longint unsigned x);
        longint unsigned total;
        longint unsigned d;
        if (x < 2)
            return 0;
        total = 1;
        for (d = 2; d * d <= x; d++)
        begin
            if (x % d == 0)
            begin
                total += d;
                if (x / d != d)
                    total += x / d;
            end
        end
        return total;
    endfunction

    function automatic verdict_t judge_candidate(logic [NUMBER_WIDTH-1:0] value);
        verdict_t        v;
        longint unsigned n;
        longint unsigned s;
        n      = 64'(value);
        s      = divisor_total(n);
        v.sum  = s[apc_pkg::SUM_WIDTH-1:0];
        v.pair = (s > n) && (divisor_total(s) == n);
        return v;
    endfunction

    // Sender: holds a word until taken, random gaps except in the tail
    always @(posedge clk or negedge rst_n)
    begin
        cand_word_t w;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            candidate <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                verdict_queue.push_back(judge_candidate(candidate));
                words_sent <= words_sent + 1;
            end
            if (in_valid && !in_ready)
                ;
            else if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (cand_queue.size() != 0 &&
                     (!cand_queue[0].drain || (verdict_queue.size() == 0 && !in_valid)))
            begin
                if (!(feed_done && cand_queue.size() < TAIL_COUNT) &&
                    $urandom_range(0, 4) == 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 3);
                end
                else
                begin
                    w         = cand_queue.pop_front();
                    in_valid  <= 1'b1;
                    candidate <= w.value;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: compares each word, one long stall, random short stalls
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            recv_gap    <= 0;
            stall_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                words_seen <= words_seen + 1;
                if (verdict_queue.size() == 0)
                begin
                    $display("%0t: unexpected word, sum %0d pair %0b",
                             $time, divisor_sum, is_pair);
                    error_count++;
                end
                else
                begin
                    v = verdict_queue.pop_front();
                    if (v.pair)
                        pairs_seen++;
                    if (divisor_sum !== v.sum)
                    begin
                        $display("%0t: divisor_sum expected %0d actual %0d",
                                 $time, v.sum, divisor_sum);
                        error_count++;
                    end
                    if (is_pair !== v.pair)
                    begin
                        $display("%0t: is_pair expected %0b actual %0b",
                                 $time, v.pair, is_pair);
                        error_count++;
                    end
                end
            end
            if (stall_count != 0)
            begin
                out_ready   <= 1'b0;
                stall_count <= stall_count - 1;
            end
            else if (!stall_done && words_seen == 25)
            begin
                stall_done  <= 1'b1;
                out_ready   <= 1'b0;
                stall_count <= 60000;
            end
            else if (recv_gap != 0)
            begin
                out_ready <= 1'b0;
                recv_gap  <= recv_gap - 1;
            end
            else if (!(feed_done && cand_queue.size() < TAIL_COUNT) &&
                     $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                recv_gap  <= $urandom_range(0, 3);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("amicable_pair_checker: mismatch");
            $finish;
        end
    end

    task automatic queue_candidate(int unsigned value, bit drain);
        cand_word_t w;
        w.value = NUMBER_WIDTH'(value);
        w.drain = drain;
        cand_queue.push_back(w);
    endtask

    // Stimulus and end of run
    initial
    begin
        int unsigned known_pairs[10] = '{220, 284, 1184, 1210, 2620, 2924,
                                         5020, 5564, 6232, 17296};
        int unsigned bits;
        int unsigned i;
        rst_n = 1'b0;
        // Directed: one, smallest primes, squares, perfect numbers, pairs, extremes
        foreach (known_pairs[k])
            queue_candidate(known_pairs[k], 1'b0);
        queue_candidate(1, 1'b0);
        queue_candidate(2, 1'b0);
        queue_candidate(3, 1'b0);
        queue_candidate(4, 1'b0);
        queue_candidate(9, 1'b0);
        queue_candidate(49, 1'b0);
        queue_candidate(6, 1'b0);
        queue_candidate(28, 1'b0);
        queue_candidate(496, 1'b0);
        queue_candidate(8128, 1'b0);
        queue_candidate(18416, 1'b0);
        queue_candidate(1021, 1'b0);
        queue_candidate(32'({NUMBER_WIDTH{1'b1}}), 1'b0);
        // Random: mostly small numbers, some known pairs, a few wider ones
        for (i = 0; i < RANDOM_COUNT; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_candidate(known_pairs[$urandom_range(0, 9)], i == 40);
            else
            begin
                bits = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 20)
                                                    : $urandom_range(1, 12);
                queue_candidate(($urandom() & ((1 << bits) - 1)) | 1, i == 40);
            end
        end
        feed_done = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (cand_queue.size() != 0 || in_valid || verdict_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d and checked %0d candidates, %0d flagged as pair members,",
                 words_sent, words_seen, pairs_seen);
        $display("including squares, perfect numbers, one and the widest value.");
        if (error_count == 0)
            $display("amicable_pair_checker: match");
        else
            $display("amicable_pair_checker: mismatch");
        $finish;
    end

endmodule
